// ----- hw/rtl/fcs_pkg.sv -----
// Shared types, constants and state codes for the framed CRC-16 checksum block.
package fcs_pkg;

  localparam int unsigned CRC_W          = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned BIT_CNT_W      = 3;
  localparam int unsigned FRAME_BITS_DEF = 100;

  localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'h1021;

  localparam logic KIND_CRC = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_CLOSE,
    S_TAIL,
    S_PAD,
    S_SUM
  } fcs_state_t;

  typedef struct packed {
    logic shift;
    logic bit_in;
    logic clear;
  } crc_ctrl_t;

  typedef struct packed {
    logic add;
    logic clear;
  } sum_ctrl_t;

endpackage

// ----- hw/rtl/fcs_crc_lfsr.sv -----
// Bit-serial CRC-16 shift register, one message bit per cycle while shift is set.
module fcs_crc_lfsr (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fcs_pkg::crc_ctrl_t       ctrl,
  input  logic [fcs_pkg::CRC_W-1:0] poly,
  output logic [fcs_pkg::CRC_W-1:0] crc
);
  import fcs_pkg::*;

  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic             fb;

  // feedback is the outgoing top bit against the incoming message bit
  assign fb = crc_r[CRC_W-1] ^ ctrl.bit_in;

  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.clear) begin
      crc_nxt = '0;
    end else if (ctrl.shift) begin
      crc_nxt = {crc_r[CRC_W-2:0], 1'b0} ^ (fb ? poly : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

// ----- hw/rtl/fcs_eac_sum.sv -----
// End-around-carry accumulator of frame CRCs, with two's complement read-out.
module fcs_eac_sum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fcs_pkg::sum_ctrl_t        ctrl,
  input  logic [fcs_pkg::CRC_W-1:0] addend,
  output logic [fcs_pkg::CRC_W-1:0] sum,
  output logic [fcs_pkg::CRC_W-1:0] sum_neg
);
  import fcs_pkg::*;

  logic [CRC_W-1:0] sum_r;
  logic [CRC_W-1:0] sum_nxt;
  logic [CRC_W:0]   raw;

  assign raw = {1'b0, sum_r} + {1'b0, addend};

  always_comb begin
    sum_nxt = sum_r;
    if (ctrl.clear) begin
      sum_nxt = '0;
    end else if (ctrl.add) begin
      // fold the carry back into the low end
      sum_nxt = raw[CRC_W-1:0] + {{(CRC_W-1){1'b0}}, raw[CRC_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum     = sum_r;
  assign sum_neg = ~sum_r + {{(CRC_W-1){1'b0}}, 1'b1};

endmodule

// ----- hw/rtl/frame_crc16_with_checksum.sv -----
// Top level: framed bit-serial CRC-16 with end-around-carry checksum of the frame CRCs.
//
//  channel | ports                                   | direction | beat
//  --------+-----------------------------------------+-----------+-------------------------
//  in      | in_valid in_ready in_data_byte in_is_last | sink    | one data byte
//  out     | out_valid out_ready out_result_kind       | source    | one frame CRC or the
//          | out_result_value out_last_result        |           | final checksum
//  cfg     | cfg_wr_en cfg_wr_data                   | sink      | generator polynomial
//
// Sequence: in S_DATA each byte is shifted through the CRC register one bit a cycle,
// and the next byte is taken on its last bit. A frame that closes inside a byte
// passes through S_CLOSE, which hands its CRC to the output register, and returns to
// S_DATA; one that closes on the last bit goes on to S_IDLE, which takes the next byte.
// After the last byte S_TAIL checks for a partial frame, which S_PAD pads with zero
// bits and S_CLOSE closes; a second S_TAIL check and S_SUM for the checksum follow,
// and the next byte is then taken from S_IDLE.
// Reset (rst_n low, synchronous) clears the CRC, frame count, sum, sequencer and
// output valid flag, and restores the polynomial to 0x1021.
// A stalled output holds its beat; the sequencer waits before loading the next result.
module frame_crc16_with_checksum #(
  parameter int unsigned FRAME_BITS = fcs_pkg::FRAME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fcs_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_is_last,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_result_kind,
  output logic [fcs_pkg::CRC_W-1:0]   out_result_value,
  output logic                        out_last_result,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [fcs_pkg::CRC_W-1:0]   cfg_wr_data
);
  import fcs_pkg::*;

  localparam int unsigned FCW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [FCW-1:0] FRAME_LAST = FCW'(FRAME_BITS - 1);

  // sequencer
  fcs_state_t state_r, state_nxt;

  // byte shift register and its bit counter
  logic [BYTE_W-1:0]    byte_sr_r;
  logic [BIT_CNT_W-1:0] bit_cnt_r;
  logic                 byte_done_r;
  logic                 last_r;
  logic [FCW-1:0]       frame_cnt_r;

  // configuration
  logic [CRC_W-1:0] poly_r;

  // output register
  logic             out_valid_r;
  logic             out_kind_r;
  logic [CRC_W-1:0] out_value_r;
  logic             out_last_r;

  // control
  crc_ctrl_t        crc_ctrl;
  sum_ctrl_t        sum_ctrl;
  logic [CRC_W-1:0] crc;
  logic [CRC_W-1:0] sum;
  logic [CRC_W-1:0] sum_neg;
  logic             in_acc;
  logic             out_free;
  logic             frame_end;
  logic             byte_end;
  logic             cnt_step;
  logic             cnt_clear;
  logic             out_load;
  logic             load_kind;
  logic [CRC_W-1:0] load_value;

  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign frame_end = (frame_cnt_r == FRAME_LAST);
  assign byte_end  = (bit_cnt_r == {BIT_CNT_W{1'b1}});

  fcs_crc_lfsr u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .poly  (poly_r),
    .crc   (crc)
  );

  fcs_eac_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (sum_ctrl),
    .addend  (crc),
    .sum     (sum),
    .sum_neg (sum_neg)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (frame_end) begin
          state_nxt = S_CLOSE;
        end else if (byte_end) begin
          if (last_r) begin
            state_nxt = S_TAIL;
          end else if (!in_valid) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          if (!byte_done_r) begin
            state_nxt = S_DATA;
          end else if (last_r) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        // a frame ending exactly on the last byte needs no padding
        state_nxt = (frame_cnt_r != '0) ? S_PAD : S_SUM;
      end
      S_PAD: begin
        if (frame_end) begin
          state_nxt = S_CLOSE;
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    crc_ctrl   = '0;
    sum_ctrl   = '0;
    cnt_step   = 1'b0;
    cnt_clear  = 1'b0;
    out_load   = 1'b0;
    load_kind  = KIND_CRC;
    load_value = crc;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_DATA: begin
        crc_ctrl.shift  = 1'b1;
        crc_ctrl.bit_in = byte_sr_r[BYTE_W-1];
        cnt_step        = 1'b1;
        // take the next byte on the eighth bit when nothing else follows
        in_ready        = byte_end && !frame_end && !last_r;
      end
      S_CLOSE: begin
        if (out_free) begin
          out_load       = 1'b1;
          sum_ctrl.add   = 1'b1;
          crc_ctrl.clear = 1'b1;
          cnt_clear      = 1'b1;
        end
      end
      S_PAD: begin
        crc_ctrl.shift  = 1'b1;
        crc_ctrl.bit_in = 1'b0;
        cnt_step        = 1'b1;
      end
      S_SUM: begin
        load_kind  = KIND_SUM;
        load_value = sum_neg;
        if (out_free) begin
          out_load       = 1'b1;
          sum_ctrl.clear = 1'b1;
          crc_ctrl.clear = 1'b1;
          cnt_clear      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      byte_done_r <= 1'b0;
      last_r      <= 1'b0;
      frame_cnt_r <= '0;
      poly_r      <= CRC_POLY_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        poly_r <= cfg_wr_data;
      end

      // byte register: load on accept, otherwise advance one bit per data cycle
      if (in_acc) begin
        bit_cnt_r   <= '0;
        byte_done_r <= 1'b0;
        last_r      <= in_is_last;
      end else if (crc_ctrl.shift && (state_r == S_DATA)) begin
        bit_cnt_r <= bit_cnt_r + 1'b1;
        if (byte_end) begin
          byte_done_r <= 1'b1;
        end
      end

      if (cnt_clear) begin
        frame_cnt_r <= '0;
      end else if (cnt_step) begin
        frame_cnt_r <= frame_cnt_r + 1'b1;
      end

      // hold a waiting result until taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_sr_r <= in_data_byte;
    end else if (state_r == S_DATA) begin
      byte_sr_r <= {byte_sr_r[BYTE_W-2:0], 1'b0};
    end
    if (out_load) begin
      out_kind_r  <= load_kind;
      out_value_r <= load_value;
      out_last_r  <= (load_kind == KIND_SUM);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_value = out_value_r;
  assign out_last_result  = out_last_r;

`ifndef NO_ASSERTIONS
  // no byte is taken while a frame closes or pads, the tail is checked or the checksum goes out
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOSE || state_r == S_PAD || state_r == S_SUM || state_r == S_TAIL)
      |-> !in_ready)
    else $error("byte taken while sequencer busy");

  // the frame count never passes the frame length outside the closing cycle
  a_frame_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLOSE) |-> (frame_cnt_r <= FRAME_LAST))
    else $error("frame bit count overran");

  // after the checksum the data set state is back to zero
  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && load_kind == KIND_SUM) |=> (sum == '0 && crc == '0 && frame_cnt_r == '0))
    else $error("state not cleared after checksum");

  // a loaded result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten");
`endif

endmodule

// ----- tb/crc_check_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard class: predicts frame CRCs and the closing checksum, and checks each result beat.
package crc_check_pkg;

  import fcs_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [CRC_W-1:0] value;
    logic             last;
  } crc_result_t;

  class crc_frame_scoreboard;

    int unsigned      frame_len;
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] frame_crc;
    logic [CRC_W-1:0] crc_total;
    int unsigned      frame_fill;
    crc_result_t      awaited[$];
    int unsigned      errors;
    int unsigned      crcs_seen;
    int unsigned      sums_seen;
    int unsigned      triple_bytes;

    function new(int unsigned frame_len_i);
      frame_len    = frame_len_i;
      poly         = CRC_POLY_RST;
      frame_crc    = '0;
      crc_total    = '0;
      frame_fill   = 0;
      errors       = 0;
      crcs_seen    = 0;
      sums_seen    = 0;
      triple_bytes = 0;
    endfunction

    function void set_poly(logic [CRC_W-1:0] p);
      poly = p;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void shift_in(logic b);
      logic fb;
      fb        = frame_crc[CRC_W-1] ^ b;
      frame_crc = frame_crc << 1;
      if (fb) begin
        frame_crc = frame_crc ^ poly;
      end
      frame_fill++;
    endfunction

    // Fold the finished frame CRC into the end-around-carry sum and queue it.
    function void close_frame();
      logic [CRC_W:0] s;
      crc_result_t    r;
      s = {1'b0, crc_total} + {1'b0, frame_crc};
      if (s[CRC_W]) begin
        s = {1'b0, s[CRC_W-1:0]} + 1'b1;
      end
      crc_total = s[CRC_W-1:0];
      r.kind    = KIND_CRC;
      r.value   = frame_crc;
      r.last    = 1'b0;
      awaited   = {awaited, r};
      frame_crc  = '0;
      frame_fill = 0;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] data, logic is_last);
      int          i;
      int unsigned n_prior;
      crc_result_t r;
      n_prior = awaited.size();
      for (i = BYTE_W - 1; i >= 0; i--) begin
        shift_in(data[i]);
        if (frame_fill >= frame_len) begin
          close_frame();
        end
      end
      if (is_last) begin
        // pad a partial frame with zeros; a frame that ended exactly gets no pad
        if (frame_fill != 0) begin
          while (frame_fill < frame_len) begin
            shift_in(1'b0);
          end
          close_frame();
        end
        r.kind  = KIND_SUM;
        r.value = ~crc_total + 1'b1;
        r.last  = 1'b1;
        awaited = {awaited, r};
        frame_crc  = '0;
        frame_fill = 0;
        crc_total  = '0;
      end
      if (awaited.size() - n_prior == 3) begin
        triple_bytes++;
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endtask

    task check_result(logic kind, logic [CRC_W-1:0] value, logic last);
      crc_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result beat with nothing awaited: kind %0d value %h last %0d",
                         kind, value, last));
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind) begin
        report($sformatf("result_kind %0d, predicted %0d", kind, want.kind));
      end
      if (value !== want.value) begin
        report($sformatf("result_value %h, predicted %h (kind %0d)", value, want.value,
                         want.kind));
      end
      if (last !== want.last) begin
        report($sformatf("last_result %0d, predicted %0d", last, want.last));
      end
      if (want.kind == KIND_SUM) begin
        sums_seen++;
      end else begin
        crcs_seen++;
      end
    endtask

  endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the framed CRC-16 block with its end-around-carry checksum.
module testbench;

  import fcs_pkg::*;
  import crc_check_pkg::*;

  localparam int unsigned FRAME_LEN     = 100;
  localparam int unsigned RANDOM_BYTES  = 440;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = FRAME_LEN + 32;
  localparam int unsigned IDLE_GAP      = 12;
  // watchdog limit, set well above the slowest honest run
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_is_last;
  logic              out_valid;
  logic              out_ready;
  logic              out_result_kind;
  logic [CRC_W-1:0]  out_result_value;
  logic              out_last_result;
  logic              cfg_wr_en;
  logic [CRC_W-1:0]  cfg_wr_data;

  // calm: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit                calm;
  bit                hold_req;
  int unsigned       cycle_count;
  int unsigned       bytes_sent;
  int unsigned       sets_done;
  int unsigned       exact_sets;
  int unsigned       poly_writes;
  logic [BYTE_W-1:0] set_bytes[$];

  crc_frame_scoreboard sb = new(FRAME_LEN);

  frame_crc16_with_checksum #(
    .FRAME_BITS(FRAME_LEN)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_result_value(out_result_value),
    .out_last_result (out_last_result),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run as a failure if the handshakes stop making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results still awaited",
               cycle_count, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: sample the beat at the rising edge, choose ready at the falling edge.
  // A hold-off request drops ready for a long stretch so the block backs up into in_ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_result(out_result_kind, out_result_value, out_last_result);
      end
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  // Offer one byte; hold valid and payload until the beat is taken, then note it.
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic is_last);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 24) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_is_last   <= is_last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(data, is_last);
    bytes_sent++;
  endtask

  // Send the queued bytes as one data set, marking the final byte as last.
  task automatic play_set();
    int i;
    for (i = 0; i < set_bytes.size(); i++) begin
      send_byte(set_bytes[i], i == set_bytes.size() - 1);
    end
    sets_done++;
    if ((set_bytes.size() * BYTE_W) % FRAME_LEN == 0) begin
      exact_sets++;
    end
  endtask

  // Drop valid and wait for every awaited result, then for an idle gap.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Write the generator polynomial only with the block idle between data sets.
  task automatic write_poly(input logic [CRC_W-1:0] p);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_poly(p);
    poly_writes++;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int unsigned       set_no;
    int unsigned       random_bytes;
    int unsigned       len;
    int unsigned       pick;
    int unsigned       k;
    logic [CRC_W-1:0]  p;
    logic [BYTE_W-1:0] b;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_is_last   = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    set_no       = 0;
    random_bytes = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed sets. Run the first on the reset polynomial, with data extremes.
    set_bytes = {8'h00, 8'hFF, 8'h80};
    play_set();

    // Zero polynomial: the feedback has no effect, so the CRC stays zero.
    write_poly(16'h0000);
    set_bytes = {8'h01, 8'hFF};
    play_set();

    // All-ones polynomial, then a set whose last byte is all zeros.
    write_poly(16'hFFFF);
    set_bytes = {8'h7F, 8'h00};
    play_set();

    // Thirteen bytes: a frame closes inside the last byte, the rest is padded,
    // so that byte yields a frame CRC, a padded frame CRC and the checksum.
    write_poly(CRC_POLY_RST);
    set_bytes.delete();
    for (k = 0; k < 13; k++) begin
      b = (k % 2 == 0) ? 8'h55 : 8'hA5;
      set_bytes = {set_bytes, b};
    end
    play_set();

    // Random sets: lengths lean towards exact frame ends (25 and 50 bytes) and
    // towards the thirteen-byte three-result case; contents mostly random.
    while (random_bytes < RANDOM_BYTES) begin
      set_no++;
      if (set_no % 5 == 0) begin
        case ($urandom_range(0, 5))
          0:       p = 16'h0000;
          1:       p = 16'hFFFF;
          2:       p = CRC_POLY_RST;
          3:       p = 16'h8000;
          4:       p = 16'h0001;
          default: p = 16'($urandom_range(0, 65535));
        endcase
        write_poly(p);
      end
      calm = (set_no >= 8 && set_no <= 12);
      // pause the sender until everything is back, without touching the register
      if (set_no == 18) begin
        wait_drained();
      end

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = 25 * $urandom_range(1, 2);
      end else if (pick < 25) begin
        len = 13;
      end else if (pick < 32) begin
        len = 1;
      end else begin
        len = $urandom_range(2, 40);
      end
      // the hold-off set must be long enough to back the block up
      if (set_no == 15) begin
        len = 40;
        hold_req = 1'b1;
      end

      set_bytes.delete();
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        set_bytes = {set_bytes, b};
      end
      play_set();
      random_bytes += len;
    end
    calm = 1'b0;

    // Drain: wait for every awaited beat, then settle to catch stray results.
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d sets (%0d on a frame boundary), %0d poly writes",
             bytes_sent, sets_done, exact_sets, poly_writes);
    $display("checked %0d CRCs, %0d checksums, %0d three-result bytes, %0d mismatches",
             sb.crcs_seen, sb.sums_seen, sb.triple_bytes, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- frame_crc16_with_checksum.f -----
hw/rtl/fcs_pkg.sv
hw/rtl/fcs_crc_lfsr.sv
hw/rtl/fcs_eac_sum.sv
hw/rtl/frame_crc16_with_checksum.sv
tb/crc_check_pkg.sv
tb/testbench.sv
